/* src/amph_pkg.sv */
// amph_pkg: shared widths, register indexes, reset values and types for the
// accelerometer magnitude / peak-hold block. No dependencies.
package amph_pkg;

    localparam int NUM_AXES    = 3;
    localparam int RAW_W       = 16;
    localparam int CFG_W       = 16;
    localparam int HOLD_W      = 8;
    localparam int AXIS_W      = 17;
    localparam int MAG_W       = 17;
    localparam int NUM_W       = 31;   // 2*|n| + |d|, |n| = |2*raw - bias2| * 4096
    localparam int DEN_W       = 17;   // 2*|sens2|
    localparam int REM_W       = 16;   // divider remainder, below DEN unless the lane is flagged zero or overflow
    localparam int QUO_W       = 17;
    localparam int SUM_W       = 34;   // sum of three squares
    localparam int PROD_W      = 33;   // decay_coeff * difference
    localparam int DIV_STEPS   = 17;
    localparam int CNT_W       = 5;
    localparam int SQ_TERMS    = 3;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 88;
    localparam int CFG_IDX_W   = 3;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = 1;
    localparam int Q_CNT_W     = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_X2     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_Y2     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_Z2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_X2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_Y2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_Z2     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_COEFF = 3'd7;

    // reset values
    localparam logic [CFG_W-1:0]  BIAS_RST  = 16'd0;
    localparam logic [CFG_W-1:0]  SENS_RST  = 16'd8192;
    localparam logic [HOLD_W-1:0] HOLD_RST  = 8'd50;
    localparam logic [CFG_W-1:0]  DECAY_RST = 16'd3277;

    localparam logic [AXIS_W-1:0] AXIS_MAX  = 17'h0FFFF;  //  65535
    localparam logic [AXIS_W-1:0] AXIS_MIN  = 17'h10000;  // -65536
    localparam logic [SUM_W-1:0]  MAG_MAX   = 34'd131071;
    localparam logic [SUM_W-1:0]  SQRT_BIT0 = 34'h1_0000_0000;
    localparam logic [SUM_W-1:0]  ROUND_HALF = 34'd32768;

    typedef struct packed {
        logic [NUM_AXES-1:0][CFG_W-1:0] bias2;
        logic [NUM_AXES-1:0][CFG_W-1:0] sens2;
        logic [HOLD_W-1:0]              hold_limit;
        logic [CFG_W-1:0]               decay_coeff;
    } cfg_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic             zero;
        logic             ovf;
    } lane_t;

    typedef struct packed {
        lane_t [NUM_AXES-1:0] lane;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DIV,
        B_FIX,
        B_SQ,
        B_SQRT,
        B_MAG,
        B_MULT,
        B_APPLY,
        B_OUT
    } back_state_t;

    typedef struct packed {
        logic pop;
        logic div_load;
        logic div_step;
        logic fix;
        logic sq;
        logic sqrt_step;
        logic mag;
        logic mult;
        logic apply;
        logic out_load;
    } back_ctl_t;

endpackage

/* src/amph_front.sv */
// amph_front: input acceptance and per-axis classification (sign, zero
// sensitivity, quotient overflow, rounded dividend). Depends on amph_pkg.
module amph_front
(
    input  amph_pkg::cfg_t                        cfg,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [amph_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  amph_pkg::q_stat_t                     q_stat,
    output logic                                  push,
    output amph_pkg::entry_t                      entry
);

    logic [17:0]                    raw2   [amph_pkg::NUM_AXES];
    logic [17:0]                    bias_e [amph_pkg::NUM_AXES];
    logic [17:0]                    diff   [amph_pkg::NUM_AXES];
    logic [17:0]                    diff_a [amph_pkg::NUM_AXES];
    logic [16:0]                    sens_e [amph_pkg::NUM_AXES];
    logic [16:0]                    sens_a [amph_pkg::NUM_AXES];
    logic [amph_pkg::NUM_W-1:0]     num    [amph_pkg::NUM_AXES];
    logic [amph_pkg::DEN_W-1:0]     den    [amph_pkg::NUM_AXES];
    logic [amph_pkg::RAW_W-1:0]     raw    [amph_pkg::NUM_AXES];

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        for (int i = 0; i < amph_pkg::NUM_AXES; i++)
        begin
            raw[i]    = s_tdata[i*amph_pkg::RAW_W +: amph_pkg::RAW_W];
            raw2[i]   = {raw[i][15], raw[i], 1'b0};
            bias_e[i] = {{2{cfg.bias2[i][15]}}, cfg.bias2[i]};
            diff[i]   = raw2[i] - bias_e[i];
            diff_a[i] = diff[i][17] ? (18'd0 - diff[i]) : diff[i];
            sens_e[i] = {cfg.sens2[i][15], cfg.sens2[i]};
            sens_a[i] = cfg.sens2[i][15] ? (17'd0 - sens_e[i]) : sens_e[i];
            // rounded dividend 2*|n| + |d| with |n| = |diff| * 4096
            num[i]    = {1'b0, diff_a[i][16:0], 13'd0} + {15'd0, sens_a[i][15:0]};
            den[i]    = {sens_a[i][15:0], 1'b0};
            entry.lane[i].num  = num[i];
            entry.lane[i].den  = den[i];
            entry.lane[i].neg  = diff[i][17] ^ cfg.sens2[i][15];
            entry.lane[i].zero = (cfg.sens2[i] == 16'd0);
            // quotient of 2^17 or more always clips
            entry.lane[i].ovf  = ({3'd0, num[i]} >= {den[i], 17'd0});
        end
    end

endmodule

/* src/amph_queue.sv */
// amph_queue: two-entry request queue between front and back.
// Depends on amph_pkg.
module amph_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  amph_pkg::entry_t  wr_data,
    input  logic              pop,
    output amph_pkg::entry_t  rd_data,
    output amph_pkg::q_stat_t q_stat
);

    amph_pkg::entry_t                q_mem [amph_pkg::Q_DEPTH];
    logic [amph_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [amph_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [amph_pkg::Q_CNT_W-1:0]    cnt_reg, cnt_next;

    assign q_stat.full  = (cnt_reg == amph_pkg::Q_CNT_W'(amph_pkg::Q_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign rd_data      = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* src/amph_back.sv */
// amph_back: sequencer for division, squares, square root and peak hold,
// with the output register. Depends on amph_pkg.
module amph_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  amph_pkg::cfg_t                       cfg,
    input  amph_pkg::entry_t                     q_data,
    input  amph_pkg::q_stat_t                    q_stat,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [amph_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    amph_pkg::back_state_t           state_reg, state_next;
    amph_pkg::back_ctl_t             ctl;
    logic [amph_pkg::CNT_W-1:0]      cnt_reg, cnt_next;

    // divider lanes
    logic [amph_pkg::QUO_W-1:0]      nlow_reg [amph_pkg::NUM_AXES];
    logic [amph_pkg::REM_W-1:0]      rem_reg  [amph_pkg::NUM_AXES];
    logic [amph_pkg::QUO_W-1:0]      quo_reg  [amph_pkg::NUM_AXES];
    logic [amph_pkg::DEN_W-1:0]      den_reg  [amph_pkg::NUM_AXES];
    logic [amph_pkg::NUM_AXES-1:0]   neg_reg, zero_reg, ovf_reg;
    logic [amph_pkg::DEN_W-1:0]      trial    [amph_pkg::NUM_AXES];
    logic [amph_pkg::NUM_AXES-1:0]   qbit;

    logic [amph_pkg::AXIS_W-1:0]     acc_reg  [amph_pkg::NUM_AXES];
    logic [amph_pkg::AXIS_W:0]       fixed    [amph_pkg::NUM_AXES];
    logic                            sat_reg;

    // squares and root
    logic signed [amph_pkg::AXIS_W-1:0] sq_sel;
    logic signed [amph_pkg::SUM_W-1:0]  sq_full;
    logic [amph_pkg::SUM_W-1:0]      prod_reg, sum_reg, res_reg, bit_reg;
    logic [amph_pkg::SUM_W-1:0]      rt_trial, rnd;

    // peak hold
    logic [amph_pkg::MAG_W-1:0]      mag_reg, peak_reg, pdiff;
    logic [amph_pkg::HOLD_W-1:0]     hold_reg;
    logic [amph_pkg::PROD_W-1:0]     dprod_reg;
    logic [amph_pkg::SUM_W-1:0]      dstep;

    logic                            out_valid_reg;
    logic [amph_pkg::OUT_TDATA_W-1:0] out_data_reg;

    function automatic logic [amph_pkg::AXIS_W:0] fix_axis
    (
        input logic [amph_pkg::QUO_W-1:0] q,
        input logic                       neg,
        input logic                       zero,
        input logic                       ovf
    );
        logic [amph_pkg::AXIS_W-1:0] v;
        logic                        f;
        f = 1'b0;
        if (zero || ovf)
        begin
            f = 1'b1;
            v = neg ? amph_pkg::AXIS_MIN : amph_pkg::AXIS_MAX;
        end
        else if (neg)
        begin
            if (q > 17'd65536)
            begin
                f = 1'b1;
                v = amph_pkg::AXIS_MIN;
            end
            else
            begin
                v = 17'd0 - q;
            end
        end
        else if (q > 17'd65535)
        begin
            f = 1'b1;
            v = amph_pkg::AXIS_MAX;
        end
        else
        begin
            v = q;
        end
        return {f, v};
    endfunction

    assign pop      = ctl.pop;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            amph_pkg::B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = amph_pkg::B_DIV;
                end
            end
            amph_pkg::B_DIV:
            begin
                if (cnt_reg == amph_pkg::CNT_W'(amph_pkg::DIV_STEPS - 1))
                begin
                    state_next = amph_pkg::B_FIX;
                end
            end
            amph_pkg::B_FIX:   state_next = amph_pkg::B_SQ;
            amph_pkg::B_SQ:
            begin
                if (cnt_reg == amph_pkg::CNT_W'(amph_pkg::SQ_TERMS))
                begin
                    state_next = amph_pkg::B_SQRT;
                end
            end
            amph_pkg::B_SQRT:
            begin
                if (bit_reg[0])
                begin
                    state_next = amph_pkg::B_MAG;
                end
            end
            amph_pkg::B_MAG:   state_next = amph_pkg::B_MULT;
            amph_pkg::B_MULT:  state_next = amph_pkg::B_APPLY;
            amph_pkg::B_APPLY: state_next = amph_pkg::B_OUT;
            amph_pkg::B_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = amph_pkg::B_IDLE;
                end
            end
            default:           state_next = amph_pkg::B_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        ctl = '0;
        case (state_reg)
            amph_pkg::B_IDLE:
            begin
                ctl.pop      = !q_stat.empty;
                ctl.div_load = !q_stat.empty;
            end
            amph_pkg::B_DIV:   ctl.div_step  = 1'b1;
            amph_pkg::B_FIX:   ctl.fix       = 1'b1;
            amph_pkg::B_SQ:    ctl.sq        = 1'b1;
            amph_pkg::B_SQRT:  ctl.sqrt_step = 1'b1;
            amph_pkg::B_MAG:   ctl.mag       = 1'b1;
            amph_pkg::B_MULT:  ctl.mult      = 1'b1;
            amph_pkg::B_APPLY: ctl.apply     = 1'b1;
            amph_pkg::B_OUT:   ctl.out_load  = !out_valid_reg || m_tready;
            default:           ctl           = '0;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.div_load || ctl.fix)
        begin
            cnt_next = '0;
        end
        else if (ctl.div_step || ctl.sq)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // datapath helpers
    always_comb
    begin
        for (int i = 0; i < amph_pkg::NUM_AXES; i++)
        begin
            trial[i] = {rem_reg[i], nlow_reg[i][amph_pkg::QUO_W-1]};
            qbit[i]  = (trial[i] >= den_reg[i]);
            fixed[i] = fix_axis(quo_reg[i], neg_reg[i], zero_reg[i], ovf_reg[i]);
        end
        case (cnt_reg[1:0])
            2'd0:    sq_sel = acc_reg[0];
            2'd1:    sq_sel = acc_reg[1];
            default: sq_sel = acc_reg[2];
        endcase
        sq_full  = sq_sel * sq_sel;
        rt_trial = res_reg + bit_reg;
        rnd      = (sum_reg > res_reg) ? res_reg + 1'b1 : res_reg;
        pdiff    = peak_reg - mag_reg;
        dstep    = {1'b0, dprod_reg} + amph_pkg::ROUND_HALF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= amph_pkg::B_IDLE;
            cnt_reg       <= '0;
            peak_reg      <= '0;
            hold_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (ctl.apply)
            begin
                if (mag_reg >= peak_reg)
                begin
                    peak_reg <= mag_reg;
                    hold_reg <= '0;
                end
                else if (hold_reg < cfg.hold_limit)
                begin
                    hold_reg <= hold_reg + 1'b1;
                end
                else
                begin
                    peak_reg <= peak_reg - dstep[16 +: amph_pkg::MAG_W];
                end
            end
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < amph_pkg::NUM_AXES; i++)
        begin
            if (ctl.div_load)
            begin
                nlow_reg[i] <= q_data.lane[i].num[amph_pkg::QUO_W-1:0];
                rem_reg[i]  <= {2'd0, q_data.lane[i].num[amph_pkg::NUM_W-1:amph_pkg::QUO_W]};
                den_reg[i]  <= q_data.lane[i].den;
                quo_reg[i]  <= '0;
                neg_reg[i]  <= q_data.lane[i].neg;
                zero_reg[i] <= q_data.lane[i].zero;
                ovf_reg[i]  <= q_data.lane[i].ovf;
            end
            else if (ctl.div_step)
            begin
                nlow_reg[i] <= {nlow_reg[i][amph_pkg::QUO_W-2:0], 1'b0};
                rem_reg[i]  <= qbit[i] ? amph_pkg::REM_W'(trial[i] - den_reg[i])
                                       : trial[i][amph_pkg::REM_W-1:0];
                quo_reg[i]  <= {quo_reg[i][amph_pkg::QUO_W-2:0], qbit[i]};
            end
            if (ctl.fix)
            begin
                acc_reg[i] <= fixed[i][amph_pkg::AXIS_W-1:0];
            end
        end

        if (ctl.fix)
        begin
            sat_reg <= fixed[0][amph_pkg::AXIS_W] | fixed[1][amph_pkg::AXIS_W]
                     | fixed[2][amph_pkg::AXIS_W];
            sum_reg <= '0;
            res_reg <= '0;
            bit_reg <= amph_pkg::SQRT_BIT0;
        end
        else if (ctl.sq)
        begin
            // one square per cycle into prod_reg, then added from prod_reg into sum_reg
            if (cnt_reg < amph_pkg::CNT_W'(amph_pkg::SQ_TERMS))
            begin
                prod_reg <= amph_pkg::SUM_W'(unsigned'(sq_full));
            end
            if (cnt_reg != '0)
            begin
                sum_reg <= sum_reg + prod_reg;
            end
        end
        else if (ctl.sqrt_step)
        begin
            // sum_reg serves as the root remainder
            if (sum_reg >= rt_trial)
            begin
                sum_reg <= sum_reg - rt_trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        else if (ctl.mag)
        begin
            if (rnd > amph_pkg::MAG_MAX)
            begin
                mag_reg <= amph_pkg::MAG_MAX[amph_pkg::MAG_W-1:0];
                sat_reg <= 1'b1;
            end
            else
            begin
                mag_reg <= rnd[amph_pkg::MAG_W-1:0];
            end
        end

        if (ctl.mult)
        begin
            dprod_reg <= cfg.decay_coeff * pdiff;
        end

        if (ctl.out_load)
        begin
            out_data_reg <= {2'd0, sat_reg, peak_reg, mag_reg,
                             acc_reg[2], acc_reg[1], acc_reg[0]};
        end
    end

endmodule

/* src/accel_magnitude_peak_hold.sv */
// accel_magnitude_peak_hold: top level with configuration registers, front,
// request queue and back sequencer. Depends on amph_pkg and the amph_* modules.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------------
//  s_*      | in        | s_tvalid / s_tready        | raw_x, raw_y, raw_z
//  m_*      | out       | m_tvalid / m_tready        | accel_x/y/z, magnitude, peak, sat
//  cfg_*    | in        | cfg_we (no wait)           | cfg_index, cfg_data
//
// In the back sequencer each request passes in turn through the three parallel
// restoring dividers, the shared squaring multiplier, the bit-pair square root
// and then the peak update and output.
// The two-entry queue lets the front accept requests while the back works.
// Reset clears the state machine, queue, peak value, hold count and the
// output valid; configuration returns to its defaults.
// A stalled output holds in the output register; the back then waits
// before loading the next result, and the queue fills behind it.
module accel_magnitude_peak_hold
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // raw_x[15:0], raw_y[31:16], raw_z[47:32]
    input  logic [amph_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // accel_x[16:0], accel_y[33:17], accel_z[50:34], magnitude[67:51],
    // peak_filtered[84:68], saturated[85], zero pad[87:86]
    output logic [amph_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                 cfg_we,
    input  logic [amph_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [amph_pkg::CFG_W-1:0]           cfg_data
);

    amph_pkg::cfg_t    cfg_reg;
    amph_pkg::entry_t  entry;
    amph_pkg::entry_t  q_data;
    amph_pkg::q_stat_t q_stat;
    logic              push;
    logic              pop;

    // configuration registers; the user must write them only while the block is idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bias2       <= {amph_pkg::NUM_AXES{amph_pkg::BIAS_RST}};
            cfg_reg.sens2       <= {amph_pkg::NUM_AXES{amph_pkg::SENS_RST}};
            cfg_reg.hold_limit  <= amph_pkg::HOLD_RST;
            cfg_reg.decay_coeff <= amph_pkg::DECAY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                amph_pkg::REG_BIAS_X2:     cfg_reg.bias2[0]    <= cfg_data;
                amph_pkg::REG_BIAS_Y2:     cfg_reg.bias2[1]    <= cfg_data;
                amph_pkg::REG_BIAS_Z2:     cfg_reg.bias2[2]    <= cfg_data;
                amph_pkg::REG_SENS_X2:     cfg_reg.sens2[0]    <= cfg_data;
                amph_pkg::REG_SENS_Y2:     cfg_reg.sens2[1]    <= cfg_data;
                amph_pkg::REG_SENS_Z2:     cfg_reg.sens2[2]    <= cfg_data;
                amph_pkg::REG_HOLD_LIMIT:  cfg_reg.hold_limit  <= cfg_data[amph_pkg::HOLD_W-1:0];
                amph_pkg::REG_DECAY_COEFF: cfg_reg.decay_coeff <= cfg_data;
                default:                   cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // front: accept and classify each axis
    amph_front u_front
    (
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .push     (push),
        .entry    (entry)
    );

    // short queue decoupling front from back
    amph_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (entry),
        .pop     (pop),
        .rd_data (q_data),
        .q_stat  (q_stat)
    );

    // back: divide, magnitude, peak hold, output register
    amph_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_data   (q_data),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
